@@ design/rsrm_pkg.sv @@
`timescale 1ns / 1ps

package rsrm_pkg;

    localparam int NUM_EPS       = 16;
    localparam int MAX_SLOTS     = 32;
    localparam int MAX_SLOT_LOG2 = 12;

    localparam int EP_W   = (NUM_EPS > 1) ? $clog2(NUM_EPS) : 1;
    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

    // operation codes
    localparam logic [1:0] FN_ALLOC  = 2'd0;
    localparam logic [1:0] FN_COMMIT = 2'd1;
    localparam logic [1:0] FN_FETCH  = 2'd2;
    localparam logic [1:0] FN_ACK    = 2'd3;

    // status codes
    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_NO_SPACE   = 3'd1;
    localparam logic [2:0] STAT_VPE_GONE   = 3'd2;
    localparam logic [2:0] STAT_TOO_LONG   = 3'd3;
    localparam logic [2:0] STAT_EMPTY      = 3'd4;
    localparam logic [2:0] STAT_FULL       = 3'd5;
    localparam logic [2:0] STAT_BAD_OFFSET = 3'd6;

    // configuration register indexes
    localparam logic [1:0] REG_SLOT_COUNT     = 2'd0;
    localparam logic [1:0] REG_SLOT_SIZE_LOG2 = 2'd1;
    localparam logic [1:0] REG_CURRENT_VPE    = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  endpoint;
        logic [15:0] target_vpe;
        logic [12:0] msg_length;
        logic [16:0] msg_offset;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  slot_index;
        logic [16:0] slot_offset;
        logic [5:0]  pending_count;
    } out_item_t;

    typedef struct packed {
        logic [MAX_SLOTS-1:0] occupied;
        logic [MAX_SLOTS-1:0] unread;
        logic [SLOT_W-1:0]    wpos;
        logic [SLOT_W-1:0]    rpos;
        logic [CNT_W-1:0]     count;
    } ep_state_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } hit_t;

    // lowest set bit
    function automatic hit_t first_one(input logic [MAX_SLOTS-1:0] v);
        hit_t r;
        r = '0;
        for (int j = MAX_SLOTS - 1; j >= 0; j--) begin
            if (v[j]) begin
                r.found = 1'b1;
                r.idx   = SLOT_W'(j);
            end
        end
        return r;
    endfunction

    // first candidate at or after start, wrapping; cand is already limited to the ring
    function automatic hit_t ring_search(input logic [MAX_SLOTS-1:0] cand,
                                         input logic [SLOT_W-1:0]    start);
        logic [MAX_SLOTS-1:0] upper;
        hit_t                 hi_hit;
        for (int j = 0; j < MAX_SLOTS; j++) begin
            upper[j] = cand[j] && (SLOT_W'(j) >= start);
        end
        hi_hit = first_one(upper);
        return hi_hit.found ? hi_hit : first_one(cand);
    endfunction

endpackage

@@ design/receive_slot_ring_manager_top.sv @@
`timescale 1ns / 1ps

// Receive slot ring manager: one operation word (alloc, commit, fetch, ack) on
// an endpoint in, one result word out. The endpoint's state is read from a
// registered-output state memory in the accept cycle, then searched, updated
// and written back while the result is loaded into the output register; the
// input is ready again the cycle after. A result left waiting on m_ready holds
// the update cycle. Endpoint state clears at once on reset through per-endpoint
// valid bits. Configuration words are taken any cycle and must only be written
// while the block is idle.
module receive_slot_ring_manager_top
    import rsrm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic {S_IDLE, S_EXEC} fsm_t;

    fsm_t        state_reg;
    logic        m_valid_reg;
    out_item_t   m_data_reg;
    in_item_t    req_reg;

    logic [5:0]  slot_count_reg;
    logic [3:0]  slot_size_log2_reg;
    logic [15:0] current_vpe_reg;

    ep_state_t   mem [NUM_EPS];
    ep_state_t   rd_data_reg;
    logic        rd_valid_reg;
    logic [NUM_EPS-1:0] ep_valid_reg;

    logic        accept;
    logic        out_free;
    logic        mem_we;
    logic [EP_W-1:0] rd_addr;
    logic [EP_W-1:0] wr_addr;

    logic [CNT_W-1:0]     n;
    logic [3:0]           lg;
    logic [MAX_SLOTS-1:0] ring_mask;
    ep_state_t            cur;
    ep_state_t            upd;
    hit_t                 free_hit;
    hit_t                 unread_hit;
    logic [16:0]          off_idx;
    logic [SLOT_W-1:0]    op_idx;
    logic [13:0]          slot_bytes;
    logic                 ep_in_range;
    logic [2:0]           status;
    logic [SLOT_W-1:0]    idx;
    logic [CNT_W-1:0]     idx_inc;
    logic [SLOT_W-1:0]    next_pos;
    out_item_t            result;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign out_free  = !m_valid_reg || m_ready;
    assign mem_we    = (state_reg == S_EXEC) && out_free && ep_in_range;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;
    assign rd_addr   = s_data.endpoint[EP_W-1:0];
    assign wr_addr   = req_reg.endpoint[EP_W-1:0];

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg     <= 6'd32;
            slot_size_log2_reg <= 4'd8;
            current_vpe_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SLOT_COUNT:     slot_count_reg     <= cfg_data[5:0];
                REG_SLOT_SIZE_LOG2: slot_size_log2_reg <= cfg_data[3:0];
                REG_CURRENT_VPE:    current_vpe_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // endpoint state memory
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= ep_valid_reg[rd_addr];
            req_reg      <= s_data;
        end
        if (mem_we) begin
            mem[wr_addr] <= upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ep_valid_reg <= '0;
        end else if (mem_we) begin
            ep_valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_comb begin
        n  = (slot_count_reg > 6'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(slot_count_reg);
        lg = (slot_size_log2_reg < 4'd4) ? 4'd4 :
             (slot_size_log2_reg > 4'(MAX_SLOT_LOG2)) ? 4'(MAX_SLOT_LOG2) : slot_size_log2_reg;
        for (int j = 0; j < MAX_SLOTS; j++) begin
            ring_mask[j] = (CNT_W'(j) < n);
        end
        cur = rd_valid_reg ? rd_data_reg : '0;

        // a position beyond the ring searches from slot 0
        free_hit   = ring_search(~cur.occupied & ring_mask,
                                 (CNT_W'(cur.wpos) < n) ? cur.wpos : '0);
        unread_hit = ring_search(cur.unread & ring_mask,
                                 (CNT_W'(cur.rpos) < n) ? cur.rpos : '0);

        off_idx     = req_reg.msg_offset >> lg;
        op_idx      = off_idx[SLOT_W-1:0];
        slot_bytes  = 14'd1 << lg;
        ep_in_range = (int'(req_reg.endpoint) < NUM_EPS);

        upd    = cur;
        status = STAT_OK;
        idx    = '0;

        unique case (req_reg.func)
            FN_ALLOC: begin
                idx = free_hit.idx;
                if (req_reg.target_vpe != current_vpe_reg) begin
                    status = STAT_VPE_GONE;
                end else if ({1'b0, req_reg.msg_length} > slot_bytes) begin
                    status = STAT_TOO_LONG;
                end else if (!free_hit.found) begin
                    status = STAT_NO_SPACE;
                end else begin
                    upd.occupied[idx] = 1'b1;
                end
            end
            FN_FETCH: begin
                idx = unread_hit.idx;
                if (cur.count == '0 || !unread_hit.found) begin
                    status = STAT_EMPTY;
                end else begin
                    upd.unread[idx] = 1'b0;
                    upd.count       = cur.count - CNT_W'(1);
                end
            end
            FN_COMMIT: begin
                idx = op_idx;
                if (off_idx >= 17'(n)) begin
                    status = STAT_BAD_OFFSET;
                end else if (cur.unread[idx]) begin
                    // already unread: leave as is
                end else if (cur.count >= n) begin
                    status = STAT_FULL;
                end else begin
                    upd.unread[idx] = 1'b1;
                    upd.count       = cur.count + CNT_W'(1);
                end
            end
            FN_ACK: begin
                idx = op_idx;
                if (off_idx >= 17'(n) || !cur.occupied[idx]) begin
                    status = STAT_BAD_OFFSET;
                end else begin
                    upd.occupied[idx] = 1'b0;
                    if (cur.unread[idx]) begin
                        upd.unread[idx] = 1'b0;
                        if (cur.count != '0) begin
                            upd.count = cur.count - CNT_W'(1);
                        end
                    end
                end
            end
            default: ;
        endcase

        // advance the ring position past the hit, wrapping
        idx_inc  = CNT_W'(idx) + CNT_W'(1);
        next_pos = (idx_inc >= n) ? '0 : idx_inc[SLOT_W-1:0];
        if (status == STAT_OK && req_reg.func == FN_ALLOC) begin
            upd.wpos = next_pos;
        end
        if (status == STAT_OK && req_reg.func == FN_FETCH) begin
            upd.rpos = next_pos;
        end

        if (status != STAT_OK) begin
            idx = '0;
        end
        if (!ep_in_range) begin
            status = STAT_BAD_OFFSET;
            idx    = '0;
        end

        result.status        = status;
        result.slot_index    = 5'(idx);
        result.slot_offset   = 17'(idx) << lg;
        result.pending_count = ep_in_range ? 6'(upd.count) : 6'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    // drop the result word once it is taken
                    if (m_valid_reg && m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                    if (accept) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= result;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result raised without an update cycle");

    a_write_in_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == S_EXEC) && !s_ready)
        else $error("state write outside the update cycle");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.pending_count <= 6'(MAX_SLOTS)))
        else $error("pending count beyond ring capacity");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status != STAT_OK) |->
            (m_data_reg.slot_index == '0 && m_data_reg.slot_offset == '0))
        else $error("failed operation reports a slot");

endmodule

@@ tb/sv/receive_slot_ring_manager_top_tb.sv @@
`timescale 1ns / 1ps

import rsrm_pkg::*;

class slot_ring_tracker;
    logic [MAX_SLOTS-1:0] occ    [NUM_EPS];
    logic [MAX_SLOTS-1:0] unread [NUM_EPS];
    logic [SLOT_W-1:0]    wpos   [NUM_EPS];
    logic [SLOT_W-1:0]    rpos   [NUM_EPS];
    logic [CNT_W-1:0]     msgs   [NUM_EPS];
    logic [5:0]           slot_count;
    logic [3:0]           size_code;
    logic [15:0]          vpe;
    out_item_t            replies [$];
    int                   fails;

    function new();
        for (int e = 0; e < NUM_EPS; e++) begin
            occ[e]    = '0;
            unread[e] = '0;
            wpos[e]   = '0;
            rpos[e]   = '0;
            msgs[e]   = '0;
        end
        slot_count = 6'd32;
        size_code  = 4'd8;
        vpe        = '0;
        fails      = 0;
    endfunction

    function int ring_n();
        return (slot_count > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count);
    endfunction

    function int slot_lg();
        if (size_code < 4) return 4;
        if (size_code > MAX_SLOT_LOG2) return MAX_SLOT_LOG2;
        return int'(size_code);
    endfunction

    function int waiting();
        return replies.size();
    endfunction

    function void write_reg(logic [1:0] index, logic [15:0] data);
        case (index)
            REG_SLOT_COUNT:     slot_count = data[5:0];
            REG_SLOT_SIZE_LOG2: size_code  = data[3:0];
            REG_CURRENT_VPE:    vpe        = data;
            default: ;
        endcase
    endfunction

    // first slot below n at or after pos (wrapping) whose bit equals want; n if none
    function int find_slot(logic [MAX_SLOTS-1:0] mask, int pos, int n, bit want);
        int start;
        int i;
        start = (pos < n) ? pos : 0;
        for (int k = 0; k < n; k++) begin
            i = start + k;
            if (i >= n) i -= n;
            if (mask[i] == want) return i;
        end
        return n;
    endfunction

    function void apply_op(in_item_t op);
        int          n;
        int          lg;
        int          idx;
        int          e;
        logic [2:0]  st;
        out_item_t   r;
        n   = ring_n();
        lg  = slot_lg();
        e   = int'(op.endpoint);
        st  = STAT_OK;
        idx = 0;
        if (op.func == FN_ALLOC) begin
            if (op.target_vpe != vpe) begin
                st = STAT_VPE_GONE;
            end else if (op.msg_length > (1 << lg)) begin
                st = STAT_TOO_LONG;
            end else begin
                idx = find_slot(occ[e], int'(wpos[e]), n, 1'b0);
                if (idx >= n) begin
                    st = STAT_NO_SPACE;
                end else begin
                    occ[e][idx] = 1'b1;
                    wpos[e] = (idx + 1 >= n) ? '0 : SLOT_W'(idx + 1);
                end
            end
        end else if (op.func == FN_FETCH) begin
            if (msgs[e] == 0) begin
                st = STAT_EMPTY;
            end else begin
                idx = find_slot(unread[e], int'(rpos[e]), n, 1'b1);
                if (idx >= n) begin
                    st = STAT_EMPTY;
                end else begin
                    unread[e][idx] = 1'b0;
                    msgs[e] = msgs[e] - 1'b1;
                    rpos[e] = (idx + 1 >= n) ? '0 : SLOT_W'(idx + 1);
                end
            end
        end else begin
            idx = int'(op.msg_offset >> lg);
            if (idx >= n) begin
                st = STAT_BAD_OFFSET;
            end else if (op.func == FN_COMMIT) begin
                // a slot already unread is taken as is
                if (!unread[e][idx]) begin
                    if (msgs[e] >= n) begin
                        st = STAT_FULL;
                    end else begin
                        msgs[e] = msgs[e] + 1'b1;
                        unread[e][idx] = 1'b1;
                    end
                end
            end else if (!occ[e][idx]) begin
                st = STAT_BAD_OFFSET;
            end else begin
                occ[e][idx] = 1'b0;
                if (unread[e][idx]) begin
                    unread[e][idx] = 1'b0;
                    if (msgs[e] > 0) msgs[e] = msgs[e] - 1'b1;
                end
            end
        end
        if (st != STAT_OK) idx = 0;
        r.status        = st;
        r.slot_index    = SLOT_W'(idx);
        r.slot_offset   = 17'(idx << lg);
        r.pending_count = msgs[e];
        replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    function void check_reply(out_item_t got);
        out_item_t want;
        if (replies.size() == 0) begin
            fails++;
            $display("%0t: result word expected none actual %h", $time, got);
            return;
        end
        want = replies.pop_front();
        compare_field("status", 32'(want.status), 32'(got.status));
        compare_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
        compare_field("slot_offset", 32'(want.slot_offset), 32'(got.slot_offset));
        compare_field("pending_count", 32'(want.pending_count), 32'(got.pending_count));
    endfunction
endclass

module receive_slot_ring_manager_top_tb;

    localparam int         LIMIT      = 300000;
    localparam int         RANDOM_OPS = 1050;
    localparam logic [1:0] REG_SPARE  = 2'd3;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    bit          calm      = 1'b0;
    bit          hold_req  = 1'b0;
    int          gap_pct   = 25;
    int          cycles    = 0;

    slot_ring_tracker tracker = new();

    receive_slot_ring_manager_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) tracker.apply_op(s_data);
            if (m_valid && m_ready) tracker.check_reply(m_data);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (250) @(posedge aclk);
                hold_req = 1'b0;
            end else if (calm || $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
        end
    end

    function automatic in_item_t mk(logic [1:0] fn, logic [3:0] ep, logic [15:0] vpe,
                                    logic [12:0] len, logic [16:0] off);
        in_item_t op;
        op.func       = fn;
        op.endpoint   = ep;
        op.target_vpe = vpe;
        op.msg_length = len;
        op.msg_offset = off;
        return op;
    endfunction

    task automatic send_op(input in_item_t op);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 13);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= op;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain(input int settle);
        @(posedge aclk);
        while (tracker.waiting() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [15:0] count_word, input logic [15:0] size_word,
                            input logic [15:0] vpe_word);
        logic [1:0]  regs  [4];
        logic [15:0] words [4];
        regs[0]  = REG_SLOT_COUNT;
        regs[1]  = REG_SLOT_SIZE_LOG2;
        regs[2]  = REG_CURRENT_VPE;
        regs[3]  = REG_SPARE;
        words[0] = count_word;
        words[1] = size_word;
        words[2] = vpe_word;
        words[3] = 16'($urandom);
        s_valid <= 1'b0;
        drain(6);
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= words[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        in_item_t    op;
        int          n;
        int          lg;
        int          r;
        int          slot;
        int          start;
        int          sent;
        int          phase_len;
        int          alloc_w;
        int          ep_span;
        logic [15:0] cw;
        logic [15:0] sw;
        logic [15:0] vw;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: 32 slots of 256 bytes, process 0
        send_op(mk(FN_ALLOC,  4'd0,  16'h0000, 13'd0,    17'd0));
        send_op(mk(FN_ALLOC,  4'd0,  16'hFFFF, 13'd0,    17'd0));
        send_op(mk(FN_ALLOC,  4'd0,  16'h0000, 13'd257,  17'd0));
        send_op(mk(FN_ALLOC,  4'd0,  16'h0000, 13'd256,  17'd0));
        send_op(mk(FN_COMMIT, 4'd0,  16'h0000, 13'd0,    17'h00000));
        send_op(mk(FN_COMMIT, 4'd0,  16'h0000, 13'd0,    17'h000FF));
        send_op(mk(FN_COMMIT, 4'd0,  16'h0000, 13'd0,    17'h00500));
        send_op(mk(FN_COMMIT, 4'd0,  16'h0000, 13'd0,    17'h1FFFF));
        send_op(mk(FN_FETCH,  4'd0,  16'h0000, 13'd0,    17'd0));
        send_op(mk(FN_FETCH,  4'd0,  16'h0000, 13'd0,    17'd0));
        send_op(mk(FN_FETCH,  4'd0,  16'h0000, 13'd0,    17'd0));
        send_op(mk(FN_COMMIT, 4'd0,  16'h0000, 13'd0,    17'h00100));
        send_op(mk(FN_ACK,    4'd0,  16'h0000, 13'd0,    17'h00100));
        send_op(mk(FN_ACK,    4'd0,  16'h0000, 13'd0,    17'h00100));
        send_op(mk(FN_ALLOC,  4'd15, 16'h0000, 13'h1FFF, 17'd0));

        // three 16-byte slots; junk above the count field
        set_regs(16'hFFC3, 16'h0004, 16'hFFFF);
        send_op(mk(FN_COMMIT, 4'd1, 16'hFFFF, 13'd0,  17'd16));
        send_op(mk(FN_COMMIT, 4'd1, 16'hFFFF, 13'd0,  17'd47));
        send_op(mk(FN_ALLOC,  4'd1, 16'hFFFF, 13'd17, 17'd0));
        send_op(mk(FN_ALLOC,  4'd1, 16'hFFFF, 13'd16, 17'd0));
        send_op(mk(FN_ALLOC,  4'd1, 16'hFFFF, 13'd16, 17'd0));
        send_op(mk(FN_ALLOC,  4'd1, 16'hFFFF, 13'd16, 17'd0));
        send_op(mk(FN_ALLOC,  4'd1, 16'hFFFF, 13'd16, 17'd0));

        // shrink to two slots, size code above range: count stays full, slot 2 out of reach
        set_regs(16'hFFC2, 16'hFFFF, 16'hFFFF);
        send_op(mk(FN_COMMIT, 4'd1, 16'hFFFF, 13'd0, 17'h00000));
        send_op(mk(FN_FETCH,  4'd1, 16'hFFFF, 13'd0, 17'd0));
        send_op(mk(FN_FETCH,  4'd1, 16'hFFFF, 13'd0, 17'd0));
        send_op(mk(FN_ACK,    4'd1, 16'hFFFF, 13'd0, 17'h1FFFF));
        send_op(mk(FN_ACK,    4'd1, 16'hFFFF, 13'd0, 17'h01000));

        // empty ring
        set_regs(16'h0000, 16'h0000, 16'h0000);
        send_op(mk(FN_ALLOC,  4'd2, 16'h0000, 13'd0, 17'd0));
        send_op(mk(FN_COMMIT, 4'd2, 16'h0000, 13'd0, 17'd0));

        sent = 0;
        while (sent < RANDOM_OPS) begin
            case ($urandom_range(0, 7))
                0:       cw = 16'd1;
                1:       cw = 16'd2;
                2:       cw = 16'd32;
                3:       cw = 16'($urandom_range(0, 63)) | (16'($urandom) & 16'hFFC0);
                default: cw = 16'($urandom_range(1, 32));
            endcase
            case ($urandom_range(0, 5))
                0:       sw = 16'd4;
                1:       sw = 16'd12;
                2:       sw = 16'($urandom);
                default: sw = 16'($urandom_range(4, 12));
            endcase
            case ($urandom_range(0, 3))
                0:       vw = 16'h0000;
                1:       vw = 16'hFFFF;
                default: vw = 16'($urandom);
            endcase
            set_regs(cw, sw, vw);

            n         = tracker.ring_n();
            lg        = tracker.slot_lg();
            alloc_w   = $urandom_range(20, 55);
            gap_pct   = $urandom_range(0, 40);
            phase_len = $urandom_range(40, 150);
            case ($urandom_range(0, 2))
                0:       ep_span = 0;
                1:       ep_span = 1;
                default: ep_span = 3;
            endcase

            for (int j = 0; j < phase_len && sent < RANDOM_OPS; j++) begin
                op = in_item_t'(52'({$urandom, $urandom}));
                // mostly a few endpoints so the rings fill and wrap
                if ($urandom_range(0, 4) != 0) op.endpoint = 4'($urandom_range(0, ep_span));
                r = $urandom_range(0, 99);
                if (r < alloc_w) begin
                    op.func = FN_ALLOC;
                    if ($urandom_range(0, 9) != 0) op.target_vpe = tracker.vpe;
                    case ($urandom_range(0, 9))
                        0:       ;
                        1:       op.msg_length = 13'((1 << lg) + 1);
                        default: op.msg_length = 13'($urandom_range(0, 1 << lg));
                    endcase
                end else begin
                    if (r < alloc_w + 25)      op.func = FN_COMMIT;
                    else if (r < alloc_w + 45) op.func = FN_FETCH;
                    else                       op.func = FN_ACK;
                    slot = $urandom_range(0, 31);
                    if (n > 0) begin
                        slot = $urandom_range(0, n - 1);
                        // half the time aim at a slot that is taken
                        if ($urandom_range(0, 1) == 0) begin
                            start = slot;
                            for (int k = 0; k < n; k++) begin
                                if (tracker.occ[op.endpoint][(start + k) % n]) begin
                                    slot = (start + k) % n;
                                    break;
                                end
                            end
                        end
                    end
                    if ($urandom_range(0, 9) != 0)
                        op.msg_offset = 17'(slot << lg) | 17'($urandom & ((1 << lg) - 1));
                end
                send_op(op);
                sent++;
                if (sent == 300) hold_req = 1'b1;
                if (sent == RANDOM_OPS - 150) calm = 1'b1;
            end
        end

        s_valid <= 1'b0;
        drain(16);
        if (tracker.fails == 0 && tracker.waiting() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
